// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker module.
// Needs only the clock and reset names passed in by the user.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define MFPP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mfpp assertion failed");

// Next-cycle implication, disabled while reset is high.
`define MFPP_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mfpp assertion failed");

`endif

// File: rtl/core/mfpp_pkg.sv
// Shared types and constants for the mono frame buffer pixel packer.
// No dependencies.
`timescale 1ns / 1ps

package mfpp_pkg;

   localparam int CMD_W     = 2;
   localparam int COORD_W   = 9;
   localparam int PIX_W     = 16;
   localparam int IDX_W     = 14;
   localparam int DATA_W    = 8;
   localparam int COMPARE_W = 11;  // holds a 9-bit coordinate and a panel size up to 1024

   localparam logic [PIX_W-1:0]  THRESHOLD_RESET = 16'h7FFF;
   localparam logic [DATA_W-1:0] WHITE_BYTE      = 8'hFF;

   localparam logic [CMD_W-1:0] CMD_RGB_PIXEL = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RAW_BIT   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FILL      = 2'd2;
   localparam logic [CMD_W-1:0] CMD_READ      = 2'd3;

   // controller -> datapath
   typedef struct packed {
      logic accept;
      logic addr_en;
      logic rd_en;
      logic wr_en;
      logic clear_en;
      logic rsp_load;
   } ctl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_read;
      logic clear_last;
      logic rsp_busy;
   } dp_stat_type;

endpackage

// File: rtl/core/mfpp_ctrl.sv
// Sequencing state machine for the pixel packer.
// Depends on mfpp_pkg for the command codes and control structs.
`timescale 1ns / 1ps

module mfpp_ctrl
   import mfpp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic [CMD_W-1:0]   req_cmd,
   output logic               req_stall,
   input  dp_stat_type        stat,
   output ctl_cmd_type        cmd
);

   typedef enum logic [5:0] {
      S_CLEAR  = 6'b000001,
      S_IDLE   = 6'b000010,
      S_ADDR   = 6'b000100,
      S_READ   = 6'b001000,
      S_MODIFY = 6'b010000,
      S_RESP   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_stall    = 1'b1;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
            if (req_valid) begin
               state_in = (req_cmd == CMD_FILL) ? S_CLEAR : S_ADDR;
            end
         end
         S_ADDR: begin
            cmd.addr_en = 1'b1;
            state_in    = S_READ;
         end
         S_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = stat.is_read ? S_RESP : S_MODIFY;
         end
         S_MODIFY: begin
            cmd.wr_en = 1'b1;
            state_in  = S_IDLE;
         end
         S_RESP: begin
            // wait for the output register to free up
            if (!stat.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/core/mfpp_datapath.sv
// Datapath: coordinate mapping, frame store, read-modify-write and
// the output register. Depends on mfpp_pkg.
`timescale 1ns / 1ps

module mfpp_datapath
   import mfpp_pkg::*;
#(
   parameter int PANEL_WIDTH  = 400,
   parameter int PANEL_HEIGHT = 300
) (
   input  logic               clock,
   input  logic               reset,
   input  ctl_cmd_type        cmd,
   output dp_stat_type        stat,
   input  logic [CMD_W-1:0]   req_cmd,
   input  logic [COORD_W-1:0] req_coord_x,
   input  logic [COORD_W-1:0] req_coord_y,
   input  logic [PIX_W-1:0]   req_pixel_value,
   input  logic [IDX_W-1:0]   req_byte_index,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [IDX_W-1:0]   rsp_read_index,
   output logic [DATA_W-1:0]  rsp_read_data,
   input  logic               csr_write_enable,
   input  logic [PIX_W-1:0]   csr_write_data
);

   localparam int StoreBytes = (PANEL_WIDTH * PANEL_HEIGHT) / 8;
   localparam int AddrW      = $clog2(StoreBytes);
   localparam int XW         = $clog2(PANEL_WIDTH);
   localparam int YW         = $clog2(PANEL_HEIGHT);
   localparam int ProdW      = XW + YW + 1;
   localparam int WideW      = (ProdW > IDX_W + 1) ? ProdW : IDX_W + 1;
   localparam int Quarter    = PANEL_HEIGHT / 4;

   logic [PIX_W-1:0] thr_ff;

   // stage 1: captured on accept
   logic [XW-1:0]    px_ff;
   logic [YW-1:0]    rows_ff;
   logic             bit_ff;
   logic             hit_ff;
   logic             is_read_ff;
   logic [IDX_W-1:0] idx_ff;

   // stage 2: address
   logic [AddrW-1:0]  addr_ff;
   logic              range_ff;
   logic              wr_ok_ff;
   logic [DATA_W-1:0] mask_ff;

   logic [DATA_W-1:0] rd_q_ff;
   logic [AddrW-1:0]  clear_ff;

   logic              rsp_valid_ff;
   logic [IDX_W-1:0]  rsp_index_ff;
   logic [DATA_W-1:0] rsp_data_ff;

   logic [DATA_W-1:0] mem [StoreBytes];

   logic [COMPARE_W-1:0] x_w, y_w, px_w, py_w, rows_w;
   logic                 hit_w, bit_w;
   logic [WideW-1:0]     wide_w;
   logic [2:0]           bitpos_w;
   logic                 mem_we;
   logic [AddrW-1:0]     mem_waddr;
   logic [DATA_W-1:0]    mem_wdata;
   logic                 clear_last;

   always_comb begin
      x_w = COMPARE_W'(req_coord_x);
      y_w = COMPARE_W'(req_coord_y);
      case (req_cmd)
         CMD_RGB_PIXEL: begin
            // logical -> physical: rotate clockwise
            hit_w = (x_w < COMPARE_W'(PANEL_HEIGHT)) && (y_w < COMPARE_W'(PANEL_WIDTH));
            px_w  = COMPARE_W'(PANEL_WIDTH - 1) - y_w;
            py_w  = x_w;
            bit_w = (req_pixel_value >= thr_ff);
         end
         CMD_RAW_BIT: begin
            hit_w = (x_w < COMPARE_W'(PANEL_WIDTH)) && (y_w < COMPARE_W'(PANEL_HEIGHT));
            px_w  = x_w;
            py_w  = y_w;
            bit_w = req_pixel_value[0];
         end
         default: begin
            hit_w = 1'b0;
            px_w  = x_w;
            py_w  = y_w;
            bit_w = 1'b0;
         end
      endcase
      rows_w = COMPARE_W'(PANEL_HEIGHT - 1) - py_w;  // y axis inverted
   end

   always_comb begin
      if (is_read_ff) begin
         wide_w = WideW'(idx_ff);
      end else begin
         wide_w = (WideW'(px_ff) >> 1) * WideW'(Quarter) + (WideW'(rows_ff) >> 2);
      end
      bitpos_w = {rows_ff[1:0], px_ff[0]};
   end

   assign clear_last = (clear_ff == AddrW'(StoreBytes - 1));
   assign mem_we     = cmd.clear_en || (cmd.wr_en && wr_ok_ff);
   assign mem_waddr  = cmd.clear_en ? clear_ff : addr_ff;
   assign mem_wdata  = cmd.clear_en ? WHITE_BYTE :
                       (bit_ff ? (rd_q_ff | mask_ff) : (rd_q_ff & ~mask_ff));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.rd_en) begin
         rd_q_ff <= mem[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         px_ff      <= px_w[XW-1:0];
         rows_ff    <= rows_w[YW-1:0];
         bit_ff     <= bit_w;
         hit_ff     <= hit_w;
         is_read_ff <= (req_cmd == CMD_READ);
         idx_ff     <= req_byte_index;
      end
      if (cmd.addr_en) begin
         addr_ff  <= wide_w[AddrW-1:0];
         range_ff <= (wide_w < WideW'(StoreBytes));
         wr_ok_ff <= hit_ff && (wide_w < WideW'(StoreBytes));
         mask_ff  <= 8'h80 >> bitpos_w;
      end
      if (cmd.rsp_load) begin
         rsp_index_ff <= idx_ff;
         rsp_data_ff  <= range_ff ? rd_q_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= THRESHOLD_RESET;
         clear_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            thr_ff <= csr_write_data;
         end
         if (cmd.clear_en) begin
            clear_ff <= clear_last ? '0 : clear_ff + 1'b1;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign stat.is_read    = is_read_ff;
   assign stat.clear_last = clear_last;
   assign stat.rsp_busy   = rsp_valid_ff && rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_index = rsp_index_ff;
   assign rsp_read_data  = rsp_data_ff;

endmodule

// File: rtl/core/mono_framebuffer_pixel_packer.sv
// Mono frame buffer pixel packer: 1 bpp store in 2x4 pixel bytes, y inverted.
// Pixel write or byte read: the next accept waits until address, memory read and
// modify/respond are done; respond waits while a stall holds the output register.
// Fill: PANEL_WIDTH*PANEL_HEIGHT/8 bytes, one byte per cycle through the store.
// Reset (synchronous, high): the same clearing pass runs, with req_stall held
// high until it ends; threshold returns to 0x7FFF.
`timescale 1ns / 1ps

module mono_framebuffer_pixel_packer
   import mfpp_pkg::*;
#(
   parameter int PANEL_WIDTH  = 400,
   parameter int PANEL_HEIGHT = 300
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [CMD_W-1:0]   req_cmd,
   input  logic [COORD_W-1:0] req_coord_x,
   input  logic [COORD_W-1:0] req_coord_y,
   input  logic [PIX_W-1:0]   req_pixel_value,
   input  logic [IDX_W-1:0]   req_byte_index,
   // response channel, read commands only
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [IDX_W-1:0]   rsp_read_index,
   output logic [DATA_W-1:0]  rsp_read_data,
   // black threshold register
   input  logic               csr_write_enable,
   input  logic [PIX_W-1:0]   csr_write_data
);

   ctl_cmd_type cmd;
   dp_stat_type stat;

   // The controller takes one transaction at a time and sequences the store
   // accesses (one read then at most one write per pixel).
   mfpp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath owns the store, the mapping and the output register, so a
   // finished read can wait downstream while the next transaction is taken.
   mfpp_datapath #(
      .PANEL_WIDTH  (PANEL_WIDTH),
      .PANEL_HEIGHT (PANEL_HEIGHT)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_cmd          (req_cmd),
      .req_coord_x      (req_coord_x),
      .req_coord_y      (req_coord_y),
      .req_pixel_value  (req_pixel_value),
      .req_byte_index   (req_byte_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_index   (rsp_read_index),
      .rsp_read_data    (rsp_read_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

endmodule

// File: rtl/core/mfpp_checker.sv
// Port-level checks for the pixel packer, bound onto the top level.
// Depends on mfpp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mfpp_checker
   import mfpp_pkg::*;
#(
   parameter int PANEL_WIDTH  = 400,
   parameter int PANEL_HEIGHT = 300
) (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [IDX_W-1:0]   rsp_read_index,
   input logic [DATA_W-1:0]  rsp_read_data
);

   localparam int StoreBytes = (PANEL_WIDTH * PANEL_HEIGHT) / 8;

   logic                    past_end_w;
   logic                    rsp_busy_w;
   logic [IDX_W+DATA_W-1:0] rsp_word_w;

   assign past_end_w = (32'(rsp_read_index) >= StoreBytes);
   assign rsp_busy_w = rsp_valid && rsp_stall;
   assign rsp_word_w = {rsp_read_index, rsp_read_data};

   // clearing pass holds off requests straight after reset
   `MFPP_ASSERT_IMP(a_busy_after_reset, clock, reset, $fell(reset), req_stall)

   // one transaction in flight at a time
   `MFPP_ASSERT_NXT(a_one_at_a_time, clock, reset, req_valid && !req_stall, req_stall)

   // reads past the end of the store return zero
   `MFPP_ASSERT_IMP(a_beyond_store_zero, clock, reset, rsp_valid && past_end_w, rsp_read_data == 8'd0)

   // a stalled response holds
   `MFPP_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_busy_w, rsp_valid && $stable(rsp_word_w))

endmodule

bind mono_framebuffer_pixel_packer mfpp_checker #(
   .PANEL_WIDTH  (PANEL_WIDTH),
   .PANEL_HEIGHT (PANEL_HEIGHT)
) u_mfpp_checker (.*);

// File: test/tb_mono_framebuffer_pixel_packer.sv
`timescale 1ns / 1ps

// Self-checking bench for mono_framebuffer_pixel_packer: pixel writes, raw bit writes,
// fills and byte reads, checked against a frame store mirror kept in the bench.
// Depends on mfpp_pkg and the block itself.
module tb_mono_framebuffer_pixel_packer;
   import mfpp_pkg::*;

   localparam int PANEL_W        = 400;
   localparam int PANEL_H        = 300;
   localparam int STORE_BYTES    = PANEL_W * PANEL_H / 8;
   localparam int CYCLE_LIMIT    = 3_000_000;
   localparam int SETTLE_CYCLES  = 16;
   localparam int SQUEEZE_CYCLES = 400;
   localparam int PHASE_ITEMS    = 300;
   localparam int MAX_REPORTS    = 10;
   localparam int TOUCHED_DEPTH  = 64;

   // one transaction on the request channel
   typedef struct {
      logic [CMD_W-1:0]   cmd;
      logic [COORD_W-1:0] coord_x;
      logic [COORD_W-1:0] coord_y;
      logic [PIX_W-1:0]   pixel_value;
      logic [IDX_W-1:0]   byte_index;
   } pixel_txn_type;

   // what a read should return
   typedef struct {
      logic [IDX_W-1:0]  index;
      logic [DATA_W-1:0] data;
   } read_result_type;

   // ---------------------------------------------------------------- DUT ports
   logic               clock;
   logic               reset            = 1'b1;
   logic               req_valid        = 1'b0;
   logic               req_stall;
   logic [CMD_W-1:0]   req_cmd          = CMD_READ;
   logic [COORD_W-1:0] req_coord_x      = '0;
   logic [COORD_W-1:0] req_coord_y      = '0;
   logic [PIX_W-1:0]   req_pixel_value  = '0;
   logic [IDX_W-1:0]   req_byte_index   = '0;
   logic               rsp_valid;
   logic               rsp_stall        = 1'b0;
   logic [IDX_W-1:0]   rsp_read_index;
   logic [DATA_W-1:0]  rsp_read_data;
   logic               csr_write_enable = 1'b0;
   logic [PIX_W-1:0]   csr_write_data   = '0;

   // ---------------------------------------------------------------- bench state
   logic [DATA_W-1:0] store_mirror [STORE_BYTES];
   logic [PIX_W-1:0]  black_level;          // mirror of the threshold register
   pixel_txn_type     pending_reqs [$];     // filled by the stimulus, drained by the driver
   read_result_type   expected_reads [$];
   int                touched [$];          // recently written bytes, read back often
   int                queued_total   = 0;
   int                accepted_total = 0;
   int                fail_count     = 0;
   int                cycle_count    = 0;
   bit                req_taken      = 1'b0;
   int                req_gap        = 0;
   int                send_calm      = 0;
   int                rsp_hold_left  = 0;
   int                rsp_calm_left  = 0;
   bit                squeeze_req    = 1'b0;
   int                squeeze_left   = 0;
   int                hot_x          = 0;
   int                hot_y          = 0;

   mono_framebuffer_pixel_packer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_coord_x      (req_coord_x),
      .req_coord_y      (req_coord_y),
      .req_pixel_value  (req_pixel_value),
      .req_byte_index   (req_byte_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_index   (rsp_read_index),
      .rsp_read_data    (rsp_read_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // ---------------------------------------------------------------- frame store mirror
   // Byte address of a physical pixel, -1 when off the panel. Each byte is a block
   // 2 wide and 4 tall, rows counted from the bottom.
   function automatic int pixel_byte(int px, int py);
      if (px < 0 || py < 0 || px >= PANEL_W || py >= PANEL_H)
         return -1;
      return (px / 2) * (PANEL_H / 4) + (PANEL_H - 1 - py) / 4;
   endfunction

   // bit within the byte, MSB first: row then column
   function automatic int pixel_bit(int px, int py);
      int rows;
      rows = PANEL_H - 1 - py;
      return 7 - ((rows % 4) * 2 + px % 2);
   endfunction

   task automatic set_pixel(int px, int py, logic bit_val);
      int at;
      at = pixel_byte(px, py);
      if (at >= 0 && at < STORE_BYTES)
         store_mirror[at][pixel_bit(px, py)] = bit_val;
   endtask

   // Work out the effect of one accepted transaction; reads queue their result.
   task automatic apply_txn(pixel_txn_type t);
      read_result_type r;
      case (t.cmd)
         CMD_RGB_PIXEL: begin
            // logical (x,y) turns clockwise onto physical (width-1-y, x)
            if (t.coord_x < PANEL_H && t.coord_y < PANEL_W)
               set_pixel(PANEL_W - 1 - int'(t.coord_y), int'(t.coord_x),
                         t.pixel_value >= black_level);
         end
         CMD_RAW_BIT:
            set_pixel(int'(t.coord_x), int'(t.coord_y), t.pixel_value[0]);
         CMD_FILL:
            foreach (store_mirror[i]) store_mirror[i] = WHITE_BYTE;
         CMD_READ: begin
            r.index = t.byte_index;
            r.data  = (t.byte_index < STORE_BYTES) ? store_mirror[t.byte_index] : '0;
            expected_reads.push_back(r);
         end
         default: begin
         end
      endcase
   endtask

   // ---------------------------------------------------------------- stimulus helpers
   function automatic pixel_txn_type make_txn(logic [CMD_W-1:0] cmd, int x, int y,
                                              int pix, int idx);
      pixel_txn_type t;
      t.cmd         = cmd;
      t.coord_x     = x[COORD_W-1:0];
      t.coord_y     = y[COORD_W-1:0];
      t.pixel_value = pix[PIX_W-1:0];
      t.byte_index  = idx[IDX_W-1:0];
      return t;
   endfunction

   // Queue a transaction and remember which byte a write lands in, so that
   // later reads can look at it.
   task automatic push_txn(pixel_txn_type t);
      int at;
      at = -1;
      if (t.cmd == CMD_RGB_PIXEL && t.coord_x < PANEL_H && t.coord_y < PANEL_W)
         at = pixel_byte(PANEL_W - 1 - int'(t.coord_y), int'(t.coord_x));
      else if (t.cmd == CMD_RAW_BIT)
         at = pixel_byte(int'(t.coord_x), int'(t.coord_y));
      if (at >= 0) begin
         touched.push_back(at);
         if (touched.size() > TOUCHED_DEPTH)
            void'(touched.pop_front());
      end
      pending_reqs.push_back(t);
      queued_total++;
   endtask

   function automatic logic [PIX_W-1:0] near_threshold();
      int v;
      v = int'(black_level) + int'($urandom_range(0, 3)) - 2;
      if (v < 0)
         v = 0;
      if (v > 65535)
         v = 65535;
      return v[PIX_W-1:0];
   endfunction

   function automatic int random_read_index();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 7 && touched.size() != 0)
         return touched[$urandom_range(0, touched.size() - 1)];
      if (roll < 9)
         return $urandom_range(0, STORE_BYTES - 1);
      return $urandom_range(0, (1 << IDX_W) - 1);   // past the store now and then
   endfunction

   // Half the writes land in a small window so bytes collect several bits.
   function automatic void pick_coords(inout pixel_txn_type t, input int x_span,
                                       input int y_span);
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 5) begin
         t.coord_x = COORD_W'(hot_x + int'($urandom_range(0, 7)));
         t.coord_y = COORD_W'(hot_y + int'($urandom_range(0, 7)));
      end else if (roll < 9) begin
         t.coord_x = COORD_W'($urandom_range(0, x_span - 1));
         t.coord_y = COORD_W'($urandom_range(0, y_span - 1));
      end
      // otherwise full 9-bit values, mostly off the panel
   endfunction

   function automatic pixel_txn_type random_txn();
      pixel_txn_type t;
      int roll;
      // unused fields carry noise
      t.cmd         = CMD_READ;
      t.coord_x     = COORD_W'($urandom);
      t.coord_y     = COORD_W'($urandom);
      t.pixel_value = PIX_W'($urandom);
      t.byte_index  = IDX_W'($urandom);
      roll = $urandom_range(0, 99);
      if ($urandom_range(0, 149) == 0) begin
         t.cmd = CMD_FILL;        // rare: a fill walks the whole store
      end else if (roll < 40) begin
         t.cmd = CMD_RGB_PIXEL;
         pick_coords(t, PANEL_H, PANEL_W);
         if ($urandom_range(0, 2) == 0)
            t.pixel_value = near_threshold();
      end else if (roll < 65) begin
         t.cmd = CMD_RAW_BIT;
         pick_coords(t, PANEL_W, PANEL_H);
      end else begin
         t.byte_index = IDX_W'(random_read_index());
      end
      return t;
   endfunction

   // ---------------------------------------------------------------- phase control
   // Idle means every queued transaction taken and every read returned.
   task automatic wait_idle();
      do
         @(negedge clock);
      while (accepted_total != queued_total || expected_reads.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_threshold(logic [PIX_W-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      black_level       = value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // One threshold setting, a burst of random traffic, and a closing read so that
   // any fill still running has finished once that read comes back.
   task automatic run_phase(logic [PIX_W-1:0] threshold, bit squeeze);
      write_threshold(threshold);
      hot_x = $urandom_range(0, 290);
      hot_y = $urandom_range(0, 290);
      if (squeeze)
         squeeze_req = 1'b1;
      repeat (PHASE_ITEMS)
         push_txn(random_txn());
      push_txn(make_txn(CMD_READ, 0, 0, 0, random_read_index()));
      wait_idle();
   endtask

   // ---------------------------------------------------------------- request driver
   // Changes at the falling edge; a new transaction follows the accepted one only
   // after its gap, and a stalled transaction is held as it is.
   function automatic int sender_gap();
      int roll;
      if (send_calm > 0) begin
         send_calm--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
         send_calm = $urandom_range(20, 80);
         return 0;
      end
      if (roll < 50)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   always @(negedge clock) begin : request_drive
      pixel_txn_type t;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() != 0) begin
            t = pending_reqs.pop_front();
            req_cmd         <= t.cmd;
            req_coord_x     <= t.coord_x;
            req_coord_y     <= t.coord_y;
            req_pixel_value <= t.pixel_value;
            req_byte_index  <= t.byte_index;
            req_valid       <= 1'b1;
            req_gap          = sender_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- response stall
   // Long hold-off, counted here, so the block backs up and stalls its input.
   always @(posedge clock) begin : squeeze_count
      if (squeeze_req) begin
         squeeze_req  = 1'b0;
         squeeze_left = SQUEEZE_CYCLES;
      end else if (squeeze_left > 0) begin
         squeeze_left--;
      end
   end

   always @(negedge clock) begin : response_stall_drive
      bit hold;
      int roll;
      hold = 1'b0;
      if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         hold = 1'b1;
      end else if (rsp_calm_left > 0) begin
         rsp_calm_left--;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 3)
            rsp_calm_left = $urandom_range(20, 80);
         else if (roll < 6)
            rsp_hold_left = $urandom_range(10, 40);
         else if (roll < 30)
            rsp_hold_left = $urandom_range(1, 3);
         hold = (rsp_hold_left > 0);
      end
      rsp_stall <= hold || (squeeze_left > 0);
   end

   // ---------------------------------------------------------------- monitor
   // Sampled at the rising edge: results are checked before the transaction taken
   // at the same edge is applied to the mirror.
   function automatic bit log_fail();
      fail_count++;
      return fail_count <= MAX_REPORTS;
   endfunction

   always @(posedge clock) begin : observe
      read_result_type want;
      pixel_txn_type   t;
      req_taken = 1'b0;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_reads.size() == 0) begin
               if (log_fail())
                  $display("read result with nothing outstanding: index %0d data %02h",
                           rsp_read_index, rsp_read_data);
            end else begin
               want = expected_reads.pop_front();
               if (rsp_read_index !== want.index || rsp_read_data !== want.data) begin
                  if (log_fail())
                     $display("read mismatch: expected index %0d data %02h, got index %0d data %02h",
                              want.index, want.data, rsp_read_index, rsp_read_data);
               end
            end
         end
         if (req_valid && !req_stall) begin
            req_taken = 1'b1;
            accepted_total++;
            t.cmd         = req_cmd;
            t.coord_x     = req_coord_x;
            t.coord_y     = req_coord_y;
            t.pixel_value = req_pixel_value;
            t.byte_index  = req_byte_index;
            apply_txn(t);
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** mono_framebuffer_pixel_packer: FAILED **");
         $finish;
      end
   end

   // ---------------------------------------------------------------- test sequence
   initial begin : stimulus
      foreach (store_mirror[i]) store_mirror[i] = WHITE_BYTE;
      black_level = THRESHOLD_RESET;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // Directed: reset threshold, panel corners, threshold edge, off-panel writes,
      // reads at and past the end of the store, and a fill.
      push_txn(make_txn(CMD_RGB_PIXEL, 0, 0, 16'h0000, 16383));   // origin goes black
      push_txn(make_txn(CMD_RGB_PIXEL, 1, 0, 16'h7FFE, 0));       // one below threshold
      push_txn(make_txn(CMD_RGB_PIXEL, 299, 399, 16'h0000, 0));   // far logical corner
      push_txn(make_txn(CMD_RGB_PIXEL, 0, 0, 16'h7FFF, 0));       // at threshold: white
      push_txn(make_txn(CMD_RGB_PIXEL, 300, 0, 16'h0000, 0));     // logical x off panel
      push_txn(make_txn(CMD_RGB_PIXEL, 0, 400, 16'h0000, 0));     // logical y off panel
      push_txn(make_txn(CMD_RGB_PIXEL, 511, 511, 16'h0000, 0));
      push_txn(make_txn(CMD_READ, 511, 511, 16'hFFFF, pixel_byte(399, 0)));
      push_txn(make_txn(CMD_READ, 0, 0, 0, pixel_byte(0, 299)));
      push_txn(make_txn(CMD_RAW_BIT, 0, 0, 16'hFFFE, 16383));     // only bit 0 counts
      push_txn(make_txn(CMD_RAW_BIT, 399, 299, 16'h0000, 0));
      push_txn(make_txn(CMD_RAW_BIT, 1, 0, 16'h0001, 0));
      push_txn(make_txn(CMD_RAW_BIT, 400, 0, 16'h0000, 0));       // physical x off panel
      push_txn(make_txn(CMD_RAW_BIT, 0, 300, 16'h0000, 0));       // physical y off panel
      push_txn(make_txn(CMD_RAW_BIT, 511, 511, 16'h0000, 0));
      push_txn(make_txn(CMD_READ, 0, 0, 0, pixel_byte(0, 0)));
      push_txn(make_txn(CMD_READ, 0, 0, 0, pixel_byte(399, 299)));
      push_txn(make_txn(CMD_READ, 0, 0, 0, 0));
      push_txn(make_txn(CMD_READ, 0, 0, 0, STORE_BYTES - 1));
      push_txn(make_txn(CMD_READ, 0, 0, 0, STORE_BYTES));         // past the store: 0
      push_txn(make_txn(CMD_READ, 0, 0, 0, (1 << IDX_W) - 1));
      push_txn(make_txn(CMD_FILL, 511, 511, 16'hFFFF, 16383));
      push_txn(make_txn(CMD_READ, 0, 0, 0, pixel_byte(0, 0)));
      push_txn(make_txn(CMD_READ, 0, 0, 0, pixel_byte(399, 299)));
      wait_idle();   // also covers the clearing pass after reset

      // Random traffic under several thresholds, extremes included; the squeeze
      // falls in the third phase.
      run_phase(16'h0000, 1'b0);
      run_phase(16'hFFFF, 1'b0);
      run_phase(16'h0001, 1'b1);
      run_phase(PIX_W'($urandom_range(0, 65535)), 1'b0);
      run_phase(16'h8000, 1'b0);
      run_phase(THRESHOLD_RESET, 1'b0);

      if (fail_count == 0)
         $display("** mono_framebuffer_pixel_packer: PASSED **");
      else
         $display("** mono_framebuffer_pixel_packer: FAILED **");
      $finish;
   end

endmodule
